/* src/assert_macros.svh */
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication or plain property, sampled on the rising clock, muted in reset.
`define UHID_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

// Expression that must never be true.
`define UHID_ASSERT_NEVER(label, clk, rst_n, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
        else $error(msg);

`endif

/* src/uhid_pkg.sv */
// Package: constants and types of the USB HID endpoint finder.
package uhid_pkg;

    localparam int MAX_BYTES = 256;
    localparam int POS_W     = $clog2(MAX_BYTES + 1);

    localparam logic [7:0] T_INTERFACE  = 8'h04;
    localparam logic [7:0] T_ENDPOINT   = 8'h05;
    localparam logic [7:0] T_HID        = 8'h21;
    localparam logic [7:0] T_REPORT     = 8'h22;
    localparam logic [7:0] CLASS_HID    = 8'h03;
    localparam logic [1:0] EP_INTERRUPT = 2'd3;
    localparam logic [7:0] DIR_IN       = 8'h80;

    localparam logic [7:0] MIN_DESC_LEN  = 8'd2;
    localparam logic [7:0] MIN_IFACE_LEN = 8'd9;
    localparam logic [7:0] MIN_EP_LEN    = 8'd7;
    localparam logic [7:0] HID_LIST_OFF  = 8'd6;

    // HID descriptor entry walk: which byte of the report length comes next
    localparam logic [1:0] PH_IDLE = 2'd0;
    localparam logic [1:0] PH_LO   = 2'd1;
    localparam logic [1:0] PH_HI   = 2'd2;

    typedef struct packed {
        logic [15:0] report_length;
        logic [7:0]  poll_interval;
        logic [15:0] max_packet;
        logic [7:0]  endpoint_address;
        logic [7:0]  iface_number;
    } t_committed;

    typedef struct packed {
        logic       found;
        t_committed fields;
    } t_result;

endpackage

/* src/uhid_parse.sv */
// Descriptor walker: per-byte state update and result formation.
module uhid_parse (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_accept,
    input  logic [7:0]        i_data_byte,
    input  logic              i_last_byte,
    output uhid_pkg::t_result o_result
);

    logic [uhid_pkg::POS_W-1:0] r_pos, n_pos;
    logic [7:0]  r_off, n_off;
    logic [1:0]  r_mod3, n_mod3;          // desc offset mod 3
    logic [7:0]  r_len, n_len;
    logic [7:0]  r_type, n_type;
    logic        r_in_hid, n_in_hid;
    logic        r_have_ep, n_have_ep;
    logic        r_stopped, n_stopped;
    logic [47:0] r_pend, n_pend;
    uhid_pkg::t_committed r_com, n_com;

    logic [1:0]  phase;
    logic [2:0]  slot;
    logic        stop_here;
    logic [8:0]  off_p1;
    logic [8:0]  off_p3;

    always_comb begin
        n_pos     = r_pos;
        n_off     = r_off;
        n_mod3    = r_mod3;
        n_len     = r_len;
        n_type    = r_type;
        n_in_hid  = r_in_hid;
        n_have_ep = r_have_ep;
        n_stopped = r_stopped;
        n_pend    = r_pend;
        n_com     = r_com;
        phase     = r_pend[18:17];
        slot      = 3'(r_off - 8'd2);
        stop_here = 1'b0;
        off_p1    = {1'b0, r_off} + 9'd1;
        off_p3    = {1'b0, r_off} + 9'd3;

        if (i_accept && (r_pos < uhid_pkg::POS_W'(uhid_pkg::MAX_BYTES))) begin
            n_pos = r_pos + 1'b1;
            if (!r_stopped) begin
                if (r_off == 8'd0) begin
                    if (i_data_byte < uhid_pkg::MIN_DESC_LEN) begin
                        n_stopped = 1'b1;
                    end else begin
                        n_len  = i_data_byte;
                        n_pend = '0;
                        n_off  = 8'd1;
                        n_mod3 = 2'd1;
                    end
                end else begin
                    if (r_off == 8'd1) begin
                        n_type = i_data_byte;
                        if (i_data_byte == uhid_pkg::T_INTERFACE &&
                            r_len >= uhid_pkg::MIN_IFACE_LEN && r_have_ep) begin
                            stop_here = 1'b1;
                            n_stopped = 1'b1;
                        end
                    end else if (r_type == uhid_pkg::T_HID) begin
                        n_pend[18:17] = uhid_pkg::PH_IDLE;
                        if (phase == uhid_pkg::PH_LO) begin
                            n_pend[7:0]   = r_pend[7:0] | i_data_byte;
                            n_pend[18:17] = uhid_pkg::PH_HI;
                        end else if (phase == uhid_pkg::PH_HI) begin
                            n_pend[15:8] = r_pend[15:8] | i_data_byte;
                        end else if (!r_pend[16] && r_off >= uhid_pkg::HID_LIST_OFF &&
                                     r_mod3 == 2'd0 && off_p3 <= {1'b0, r_len} &&
                                     i_data_byte == uhid_pkg::T_REPORT) begin
                            n_pend[16]    = 1'b1;
                            n_pend[18:17] = uhid_pkg::PH_LO;
                        end
                    end else if (r_off <= 8'd7) begin
                        n_pend[{slot, 3'b000} +: 8] = i_data_byte;
                    end

                    if (!stop_here) begin
                        if (off_p1 == {1'b0, r_len}) begin
                            n_off  = 8'd0;
                            n_mod3 = 2'd0;
                            // commit the finished descriptor
                            if (n_type == uhid_pkg::T_INTERFACE &&
                                r_len >= uhid_pkg::MIN_IFACE_LEN) begin
                                n_in_hid = (n_pend[31:24] == uhid_pkg::CLASS_HID) &&
                                           (n_pend[47:40] == 8'd0);
                                if (n_in_hid) begin
                                    n_com.iface_number  = n_pend[7:0];
                                    n_com.report_length = 16'd0;
                                end
                            end else if (r_in_hid && n_type == uhid_pkg::T_HID &&
                                         r_len >= uhid_pkg::MIN_IFACE_LEN) begin
                                if (n_pend[16]) begin
                                    n_com.report_length = n_pend[15:0];
                                end
                            end else if (r_in_hid && n_type == uhid_pkg::T_ENDPOINT &&
                                         r_len >= uhid_pkg::MIN_EP_LEN) begin
                                if ((n_pend[7:0] & uhid_pkg::DIR_IN) != 8'd0 &&
                                    n_pend[9:8] == uhid_pkg::EP_INTERRUPT &&
                                    !r_have_ep) begin
                                    n_com.endpoint_address = n_pend[7:0];
                                    n_com.max_packet       = n_pend[31:16];
                                    n_com.poll_interval    = n_pend[39:32];
                                    n_have_ep              = 1'b1;
                                end
                            end
                        end else begin
                            n_off  = off_p1[7:0];
                            n_mod3 = (r_mod3 == 2'd2) ? 2'd0 : r_mod3 + 2'd1;
                        end
                    end
                end
            end
        end

        o_result.fields = n_com;
        o_result.found  = n_have_ep && (n_com.report_length != 16'd0) &&
                          (n_com.max_packet != 16'd0);

        // final byte: rearm for the next descriptor set
        if (i_accept && i_last_byte) begin
            n_pos     = '0;
            n_off     = '0;
            n_mod3    = '0;
            n_len     = '0;
            n_type    = '0;
            n_in_hid  = 1'b0;
            n_have_ep = 1'b0;
            n_stopped = 1'b0;
            n_pend    = '0;
            n_com     = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos     <= '0;
            r_off     <= '0;
            r_mod3    <= '0;
            r_len     <= '0;
            r_type    <= '0;
            r_in_hid  <= 1'b0;
            r_have_ep <= 1'b0;
            r_stopped <= 1'b0;
            r_pend    <= '0;
            r_com     <= '0;
        end else begin
            r_pos     <= n_pos;
            r_off     <= n_off;
            r_mod3    <= n_mod3;
            r_len     <= n_len;
            r_type    <= n_type;
            r_in_hid  <= n_in_hid;
            r_have_ep <= n_have_ep;
            r_stopped <= n_stopped;
            r_pend    <= n_pend;
            r_com     <= n_com;
        end
    end

endmodule

/* src/usb_hid_endpoint_finder.sv */
// Top level: USB HID endpoint finder with registered result word.
//
// Usage:
//   Input channel (i_in_valid / o_in_ready) carries one byte of a USB
//   configuration descriptor set per word, with i_last_byte marking the
//   final byte. Output channel (o_out_valid / i_out_ready) carries one
//   result word per descriptor set: found flag, interface number, IN
//   endpoint address, max packet size, poll interval, report length.
//   The result word is registered: o_out_valid rises in the cycle after the
//   final byte is taken. Throughput: one byte per cycle while o_in_ready is
//   high; the per-byte descriptor walk is a single register-to-register
//   update. Bytes past MAX_BYTES are not walked; only i_last_byte is used.
//   Reset (synchronous, active low) clears the walker state and drops
//   o_out_valid. After each final byte the walker rearms by itself.
//   Stall: while a result word waits with i_out_ready low, o_in_ready is
//   low, so no byte is taken; with i_out_ready high, a new byte (even a
//   final one) is taken in the same cycle the old word leaves.
module usb_hid_endpoint_finder (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [7:0]  i_data_byte,
    input  logic        i_last_byte,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic        o_found,
    output logic [7:0]  o_iface_number,
    output logic [7:0]  o_endpoint_address,
    output logic [15:0] o_max_packet,
    output logic [7:0]  o_poll_interval,
    output logic [15:0] o_report_length
);

    logic              accept;
    uhid_pkg::t_result result;
    logic              r_out_valid;
    uhid_pkg::t_result r_out;

    // one result slot; it frees in the cycle it is taken
    assign o_in_ready = !r_out_valid || i_out_ready;
    assign accept     = i_in_valid && o_in_ready;

    uhid_parse u_parse (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (accept),
        .i_data_byte (i_data_byte),
        .i_last_byte (i_last_byte),
        .o_result    (result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (accept && i_last_byte) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    // payload only, no reset
    always_ff @(posedge i_clk) begin
        if (accept && i_last_byte) begin
            r_out <= result;
        end
    end

    assign o_out_valid        = r_out_valid;
    assign o_found            = r_out.found;
    assign o_iface_number     = r_out.fields.iface_number;
    assign o_endpoint_address = r_out.fields.endpoint_address;
    assign o_max_packet       = r_out.fields.max_packet;
    assign o_poll_interval    = r_out.fields.poll_interval;
    assign o_report_length    = r_out.fields.report_length;

endmodule

/* src/uhid_check.sv */
// Port-level checker for the endpoint finder, bound to the top level.
`include "assert_macros.svh"

module uhid_check (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_valid,
    input logic        o_in_ready,
    input logic        i_last_byte,
    input logic        o_out_valid,
    input logic        i_out_ready,
    input logic        o_found,
    input logic [7:0]  o_endpoint_address,
    input logic [15:0] o_max_packet,
    input logic [15:0] o_report_length
);

    `UHID_ASSERT(a_out_hold, i_clk, i_rst_n,
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_found) &&
        $stable(o_max_packet) && $stable(o_report_length),
        "result word changed while stalled")
    `UHID_ASSERT(a_found_is_in, i_clk, i_rst_n,
        o_out_valid && o_found |-> o_endpoint_address[7],
        "found endpoint is not IN")
    `UHID_ASSERT_NEVER(a_found_zero, i_clk, i_rst_n,
        o_out_valid && o_found && (o_max_packet == 16'd0 || o_report_length == 16'd0),
        "found with zero size")
    `UHID_ASSERT(a_rise_from_last, i_clk, i_rst_n,
        $rose(o_out_valid) |-> $past(i_in_valid && o_in_ready && i_last_byte),
        "result without final byte")
    `UHID_ASSERT_NEVER(a_stall_blocks, i_clk, i_rst_n,
        o_out_valid && !i_out_ready && o_in_ready,
        "byte taken while result slot full")

endmodule

bind usb_hid_endpoint_finder uhid_check u_uhid_check (.*);

/* tb/tb_usb_hid_endpoint_finder.sv */
// Testbench: USB HID endpoint finder, byte stream stimulus with a self-checking walker model.
module tb_usb_hid_endpoint_finder;
    timeunit 1ns;
    timeprecision 1ps;

    // Random part length in bytes; the directed rows make up the rest of the run.
    localparam int RANDOM_ITEMS = 1400;
    // No idling on either side once this close to the end.
    localparam int CALM_TAIL    = 150;
    // Cycles with no word moving on either channel before the run is called hung.
    localparam int HANG_LIMIT   = 2000;
    // Margin after the last awaited result word has been checked.
    localparam int DRAIN_CYCLES = 4;

    localparam uhid_pkg::t_result NO_FIND  = '0;
    localparam uhid_pkg::t_result ALL_HIGH =
        {1'b1, 16'hFFFF, 8'hFF, 16'hFFFF, 8'hFF, 8'hFF};

    typedef struct packed {
        logic [7:0]        data;
        logic              last;
        logic              typed;
        uhid_pkg::t_result want;
    } t_row;

    // Directed part: a lone oversized length, a lone zero length, then a
    // minimal interface + HID + endpoint set with every field at its top value.
    localparam int N_ROWS = 27;
    localparam t_row DIRECTED [N_ROWS] = '{
        '{8'hFF,                 1'b1, 1'b1, NO_FIND},    // length cut off by the end
        '{8'h00,                 1'b1, 1'b1, NO_FIND},    // length below two
        // interface: number FF, class HID, protocol 0
        '{8'h09,                 1'b0, 1'b0, NO_FIND},
        '{uhid_pkg::T_INTERFACE, 1'b0, 1'b0, NO_FIND},
        '{8'hFF,                 1'b0, 1'b0, NO_FIND},
        '{8'h00,                 1'b0, 1'b0, NO_FIND},
        '{8'h01,                 1'b0, 1'b0, NO_FIND},
        '{uhid_pkg::CLASS_HID,   1'b0, 1'b0, NO_FIND},
        '{8'h00,                 1'b0, 1'b0, NO_FIND},
        '{8'h00,                 1'b0, 1'b0, NO_FIND},
        '{8'h00,                 1'b0, 1'b0, NO_FIND},
        // HID descriptor, one report entry of length FFFF
        '{8'h09,                 1'b0, 1'b0, NO_FIND},
        '{uhid_pkg::T_HID,       1'b0, 1'b0, NO_FIND},
        '{8'h11,                 1'b0, 1'b0, NO_FIND},
        '{8'h01,                 1'b0, 1'b0, NO_FIND},
        '{8'h00,                 1'b0, 1'b0, NO_FIND},
        '{8'h01,                 1'b0, 1'b0, NO_FIND},
        '{uhid_pkg::T_REPORT,    1'b0, 1'b0, NO_FIND},
        '{8'hFF,                 1'b0, 1'b0, NO_FIND},
        '{8'hFF,                 1'b0, 1'b0, NO_FIND},
        // endpoint: address FF, attributes FF, packet FFFF, interval FF
        '{8'h07,                 1'b0, 1'b0, NO_FIND},
        '{uhid_pkg::T_ENDPOINT,  1'b0, 1'b0, NO_FIND},
        '{8'hFF,                 1'b0, 1'b0, NO_FIND},
        '{8'hFF,                 1'b0, 1'b0, NO_FIND},
        '{8'hFF,                 1'b0, 1'b0, NO_FIND},
        '{8'hFF,                 1'b0, 1'b0, NO_FIND},
        '{8'hFF,                 1'b1, 1'b1, ALL_HIGH}
    };

    // DUT ports; every input known from time zero
    logic        i_clk        = 1'b0;
    logic        i_rst_n      = 1'b0;
    logic        i_in_valid   = 1'b0;
    logic [7:0]  i_data_byte  = '0;
    logic        i_last_byte  = 1'b0;
    logic        i_out_ready  = 1'b1;
    logic        o_in_ready;
    logic        o_out_valid;
    logic        o_found;
    logic [7:0]  o_iface_number;
    logic [7:0]  o_endpoint_address;
    logic [15:0] o_max_packet;
    logic [7:0]  o_poll_interval;
    logic [15:0] o_report_length;

    usb_hid_endpoint_finder dut (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_in_valid         (i_in_valid),
        .o_in_ready         (o_in_ready),
        .i_data_byte        (i_data_byte),
        .i_last_byte        (i_last_byte),
        .o_out_valid        (o_out_valid),
        .i_out_ready        (i_out_ready),
        .o_found            (o_found),
        .o_iface_number     (o_iface_number),
        .o_endpoint_address (o_endpoint_address),
        .o_max_packet       (o_max_packet),
        .o_poll_interval    (o_poll_interval),
        .o_report_length    (o_report_length)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Descriptor walker model
    // ------------------------------------------------------------------
    int unsigned seen_bytes;          // saturates at MAX_BYTES
    logic [7:0]  d_off, d_len, d_type;
    logic        hid_iface;           // last complete interface is HID, protocol 0
    logic        ep_taken;            // interrupt IN endpoint already committed
    logic        halted;              // walk over for this set
    logic [7:0]  body [2:7];          // header bytes of a non-HID descriptor
    logic [15:0] hid_rlen;            // report length gathered inside a HID descriptor
    logic        hid_hit;
    logic [1:0]  hid_phase;
    uhid_pkg::t_committed kept;

    function automatic void walker_clear();
        seen_bytes = 0;
        d_off      = '0;
        d_len      = '0;
        d_type     = '0;
        hid_iface  = 1'b0;
        ep_taken   = 1'b0;
        halted     = 1'b0;
        foreach (body[k]) body[k] = '0;
        hid_rlen   = '0;
        hid_hit    = 1'b0;
        hid_phase  = uhid_pkg::PH_IDLE;
        kept       = '0;
    endfunction

    // Values of a descriptor land only once its last byte is in.
    function automatic void commit_desc();
        if (d_type == uhid_pkg::T_INTERFACE && d_len >= uhid_pkg::MIN_IFACE_LEN) begin
            hid_iface = (body[5] == uhid_pkg::CLASS_HID && body[7] == 8'h00);
            if (hid_iface) begin
                kept.iface_number  = body[2];
                kept.report_length = '0;
            end
        end else if (hid_iface && d_type == uhid_pkg::T_HID &&
                     d_len >= uhid_pkg::MIN_IFACE_LEN) begin
            // HID descriptor shares the nine-byte minimum of the interface
            if (hid_hit)
                kept.report_length = hid_rlen;
        end else if (hid_iface && d_type == uhid_pkg::T_ENDPOINT &&
                     d_len >= uhid_pkg::MIN_EP_LEN) begin
            if ((body[2] & uhid_pkg::DIR_IN) != 0 &&
                body[3][1:0] == uhid_pkg::EP_INTERRUPT && !ep_taken) begin
                kept.endpoint_address = body[2];
                kept.max_packet       = {body[5], body[4]};
                kept.poll_interval    = body[6];
                ep_taken              = 1'b1;
            end
        end
    endfunction

    function automatic void walk_byte(input logic [7:0] b);
        int o;
        o = int'(d_off);
        if (o == 0) begin
            if (b < uhid_pkg::MIN_DESC_LEN) begin
                halted = 1'b1;
                return;
            end
            d_len = b;
            foreach (body[k]) body[k] = '0;
            hid_rlen  = '0;
            hid_hit   = 1'b0;
            hid_phase = uhid_pkg::PH_IDLE;
            d_off     = 8'd1;
            return;
        end
        if (o == 1) begin
            d_type = b;
            // a real interface after the endpoint ends the walk
            if (b == uhid_pkg::T_INTERFACE && d_len >= uhid_pkg::MIN_IFACE_LEN && ep_taken) begin
                halted = 1'b1;
                return;
            end
        end else if (d_type == uhid_pkg::T_HID) begin
            case (hid_phase)
                uhid_pkg::PH_LO: begin
                    hid_rlen[7:0] = b;
                    hid_phase     = uhid_pkg::PH_HI;
                end
                uhid_pkg::PH_HI: begin
                    hid_rlen[15:8] = b;
                    hid_phase      = uhid_pkg::PH_IDLE;
                end
                default: begin
                    // first report entry that fits wholly inside the descriptor
                    if (!hid_hit && o >= int'(uhid_pkg::HID_LIST_OFF) &&
                        (o - int'(uhid_pkg::HID_LIST_OFF)) % 3 == 0 &&
                        o + 3 <= int'(d_len) && b == uhid_pkg::T_REPORT) begin
                        hid_hit   = 1'b1;
                        hid_phase = uhid_pkg::PH_LO;
                    end
                end
            endcase
        end else if (o <= 7) begin
            body[o] = b;
        end
        if (o + 1 == int'(d_len)) begin
            commit_desc();
            d_off = '0;
        end else begin
            d_off = 8'(o + 1);
        end
    endfunction

    // One accepted byte; returns 1 with the report when the byte closes a set.
    function automatic bit take_byte(input logic [7:0] b, input logic last,
                                     output uhid_pkg::t_result rep);
        rep = '0;
        if (seen_bytes < uhid_pkg::MAX_BYTES) begin
            if (!halted)
                walk_byte(b);
            seen_bytes++;
        end
        if (!last)
            return 1'b0;
        rep.found  = ep_taken && kept.report_length != 0 && kept.max_packet != 0;
        rep.fields = kept;
        walker_clear();
        return 1'b1;
    endfunction

    // ------------------------------------------------------------------
    // Byte source
    // ------------------------------------------------------------------
    uhid_pkg::t_result awaited_reports [$];
    logic [7:0]  set_bytes [$];
    int          mismatches;
    int          counted_bytes;
    bit          pace_gaps;
    bit          calm;

    // Drive one word; returns at the edge where it is taken.
    task automatic send_byte(input logic [7:0] b, input logic last, input logic typed,
                             input uhid_pkg::t_result want);
        uhid_pkg::t_result rep;
        if (pace_gaps && !calm && $urandom_range(0, 6) == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 17)) @(posedge i_clk);
        end
        i_in_valid  <= 1'b1;
        i_data_byte <= b;
        i_last_byte <= last;
        do
            @(posedge i_clk);
        while (!o_in_ready);
        if (take_byte(b, last, rep))
            awaited_reports.push_back(typed ? want : rep);
    endtask

    // One descriptor set: mostly well-formed config/interface/HID/endpoint
    // chains with random content, plus noise, short lengths, cut-off tails
    // and the odd set running past MAX_BYTES.
    task automatic build_set(input int set_no);
        int         k, len, pick, cut;
        bit         zero_mps, oversize;
        logic [7:0] b;
        set_bytes.delete();
        oversize = (set_no == 3) || ($urandom_range(0, 49) == 0);
        if ($urandom_range(0, 99) < 8) begin
            repeat ($urandom_range(1, 40)) set_bytes.push_back(8'($urandom));
        end else begin
            // configuration header; the walker steps over it and commits nothing from it
            set_bytes.push_back(8'd9);
            set_bytes.push_back(8'h02);
            repeat (7) set_bytes.push_back(8'($urandom));
            repeat ($urandom_range(1, 2) + ($urandom_range(0, 4) == 0)) begin
                // interface, sometimes undersized or padded
                len = ($urandom_range(0, 7) == 0) ? $urandom_range(2, 12) : 9;
                set_bytes.push_back(8'(len));
                set_bytes.push_back(uhid_pkg::T_INTERFACE);
                for (k = 2; k < len; k++) begin
                    case (k)
                        5:       b = ($urandom_range(0, 3) != 0) ?
                                     uhid_pkg::CLASS_HID : 8'($urandom);
                        7:       b = ($urandom_range(0, 3) != 0) ?
                                     8'h00 : 8'($urandom_range(0, 2));
                        default: b = 8'($urandom);
                    endcase
                    set_bytes.push_back(b);
                end
                // HID descriptor, sometimes short, with report entries in most list slots
                if ($urandom_range(0, 5) != 0) begin
                    len = ($urandom_range(0, 2) != 0) ? 9 : $urandom_range(4, 15);
                    set_bytes.push_back(8'(len));
                    set_bytes.push_back(uhid_pkg::T_HID);
                    for (k = 2; k < len; k++) begin
                        if (k >= 6 && (k - 6) % 3 == 0 && $urandom_range(0, 4) != 0)
                            set_bytes.push_back(uhid_pkg::T_REPORT);
                        else
                            set_bytes.push_back(8'($urandom));
                    end
                end
                // endpoints
                repeat ($urandom_range(0, 3)) begin
                    len      = ($urandom_range(0, 7) == 0) ? $urandom_range(2, 10) : 7;
                    zero_mps = ($urandom_range(0, 9) == 0);
                    set_bytes.push_back(8'(len));
                    set_bytes.push_back(uhid_pkg::T_ENDPOINT);
                    for (k = 2; k < len; k++) begin
                        case (k)
                            2: b = {($urandom_range(0, 4) != 0) ? 1'b1 : 1'($urandom),
                                    7'($urandom)};
                            3: b = ($urandom_range(0, 3) != 0) ?
                                   {6'($urandom), uhid_pkg::EP_INTERRUPT} : 8'($urandom);
                            4, 5: b = zero_mps ? 8'h00 : 8'($urandom);
                            default: b = 8'($urandom);
                        endcase
                        set_bytes.push_back(b);
                    end
                end
                // stray descriptor of any type
                if ($urandom_range(0, 4) == 0) begin
                    len = $urandom_range(2, 8);
                    set_bytes.push_back(8'(len));
                    repeat (len - 1) set_bytes.push_back(8'($urandom));
                end
            end
        end
        pick = $urandom_range(0, 99);
        if (oversize) begin
            // long class-specific fillers push the walk past MAX_BYTES
            while (set_bytes.size() < 300) begin
                set_bytes.push_back(8'd255);
                set_bytes.push_back(8'h24);
                repeat (253) set_bytes.push_back(8'($urandom));
            end
            repeat ($urandom_range(0, 5)) set_bytes.push_back(8'($urandom));
        end else if (pick < 6) begin
            set_bytes.push_back(8'($urandom_range(0, 1)));
            repeat ($urandom_range(0, 10)) set_bytes.push_back(8'($urandom));
        end else if (pick < 16 && set_bytes.size() > 1) begin
            cut = $urandom_range(1, (set_bytes.size() > 13) ? 12 : set_bytes.size() - 1);
            repeat (cut) void'(set_bytes.pop_back());
        end
    endtask

    // ------------------------------------------------------------------
    // Result sink: random stall bursts, none in the tail
    // ------------------------------------------------------------------
    initial begin
        forever begin
            @(posedge i_clk);
            if (i_rst_n && !calm && $urandom_range(0, 9) == 0) begin
                i_out_ready <= 1'b0;
                repeat ($urandom_range(1, 17)) @(posedge i_clk);
                i_out_ready <= 1'b1;
            end
        end
    end

    // ------------------------------------------------------------------
    // Result check, field by field, against the oldest awaited report
    // ------------------------------------------------------------------
    function automatic void check_field(input string name, input int unsigned want,
                                        input int unsigned got);
        if (want != got) begin
            $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
            mismatches++;
        end
    endfunction

    always @(posedge i_clk) begin
        uhid_pkg::t_result want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (awaited_reports.size() == 0) begin
                $display("%0t: unexpected result word, expected none, got found=%0b iface=%0h",
                         $time, o_found, o_iface_number);
                mismatches++;
            end else begin
                want = awaited_reports.pop_front();
                check_field("found", want.found, o_found);
                check_field("iface_number", want.fields.iface_number, o_iface_number);
                check_field("endpoint_address", want.fields.endpoint_address,
                            o_endpoint_address);
                check_field("max_packet", want.fields.max_packet, o_max_packet);
                check_field("poll_interval", want.fields.poll_interval, o_poll_interval);
                check_field("report_length", want.fields.report_length, o_report_length);
            end
        end
    end

    // Hang guard: counts cycles in which no word moves on either channel.
    int still_cycles;
    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready))
            still_cycles <= 0;
        else
            still_cycles <= still_cycles + 1;
        if (still_cycles == HANG_LIMIT) begin
            $display("%0t: no progress for %0d cycles", $time, HANG_LIMIT);
            $display("Some tests failed");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial begin
        int set_no;
        mismatches    = 0;
        counted_bytes = 0;
        calm          = 1'b0;
        pace_gaps     = 1'b1;
        walker_clear();

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (DIRECTED[r])
            send_byte(DIRECTED[r].data, DIRECTED[r].last, DIRECTED[r].typed, DIRECTED[r].want);

        set_no = 0;
        while (counted_bytes < RANDOM_ITEMS) begin
            build_set(set_no);
            // some sets run back to back with no gaps at all
            pace_gaps = ($urandom_range(0, 3) != 0);
            foreach (set_bytes[k]) begin
                calm = (counted_bytes >= RANDOM_ITEMS - CALM_TAIL);
                send_byte(set_bytes[k], k == set_bytes.size() - 1, 1'b0, NO_FIND);
                counted_bytes++;
            end
            set_no++;
        end
        i_in_valid <= 1'b0;

        while (awaited_reports.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (mismatches == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
